// File: hw/rtl/rcpipe_pkg.sv
// Shared types and constants for the reference-counted pipe ring buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
package rcpipe_pkg;

   // Field widths of one item on either channel.
   localparam int ACT_W       = 3;
   localparam int BYTE_W      = 8;
   localparam int STS_W       = 3;
   localparam int XFER_W      = 16;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 32;

   // Action codes carried by an input item.
   typedef enum logic [ACT_W-1:0] {
      ACT_WRITE        = 3'd0,
      ACT_READ         = 3'd1,
      ACT_ADD_WRITER   = 3'd2,
      ACT_CLOSE_WRITER = 3'd3,
      ACT_ADD_READER   = 3'd4,
      ACT_CLOSE_READER = 3'd5
   } act_type;

   // Status codes carried by a result item.
   typedef enum logic [STS_W-1:0] {
      STS_OK    = 3'd0,
      STS_BLOCK = 3'd1,
      STS_PIPE  = 3'd2,
      STS_EOF   = 3'd3,
      STS_SHORT = 3'd4
   } sts_type;

   // Output stage state of the controller.
   typedef enum logic {
      OUT_EMPTY = 1'b0,
      OUT_FULL  = 1'b1
   } out_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic exec;   // apply the accepted item and load the result register
      logic hold;   // a result is waiting and is not taken this cycle
   } ctrl_cmd_type;

endpackage

// File: hw/rtl/rcpipe_ctrl.sv
// Controller of the pipe: handshake on both channels and the output stage state.
// Depends on rcpipe_pkg for the state and command types.
module rcpipe_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output rcpipe_pkg::ctrl_cmd_type  cmd
);
   import rcpipe_pkg::*;

   out_state_type state_ff;
   out_state_type state_in;

   // State register of the output stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OUT_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   // A new item is taken whenever the result register is free or being emptied.
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         OUT_EMPTY: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = OUT_FULL;
            end
         end
         OUT_FULL: begin
            rsp_tvalid = 1'b1;
            req_tready = rsp_tready;
            if (rsp_tready && !req_tvalid) begin
               state_in = OUT_EMPTY;
            end
         end
         default: begin
            state_in = OUT_EMPTY;
         end
      endcase
      cmd.exec = req_tvalid && req_tready;
      cmd.hold = (state_ff == OUT_FULL) && !rsp_tready;
   end

endmodule

// File: hw/rtl/rcpipe_dp.sv
// Datapath of the pipe: ring store, pointers, reference counts, request count
// and the result register. Depends on rcpipe_pkg for codes and the command type.
module rcpipe_dp #(
   parameter int DEPTH    = 4096,
   parameter int MAX_REFS = 255
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rcpipe_pkg::ctrl_cmd_type        cmd,
   input  logic [rcpipe_pkg::ACT_W-1:0]    action,
   input  logic [rcpipe_pkg::BYTE_W-1:0]   data_in,
   input  logic                            last,
   output logic [rcpipe_pkg::BYTE_W-1:0]   data_out,
   output rcpipe_pkg::sts_type             status,
   output logic [rcpipe_pkg::XFER_W-1:0]   transferred,
   output logic                            request_done
);
   import rcpipe_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(MAX_REFS + 1);
   localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  REF_LIMIT = CNT_W'(MAX_REFS);
   localparam logic [XFER_W-1:0] XFER_MAX  = '1;

   logic [BYTE_W-1:0] mem [DEPTH];

   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]  writers_ff, writers_in;
   logic [CNT_W-1:0]  readers_ff, readers_in;
   logic [XFER_W-1:0] bytes_ff, bytes_in;
   logic [BYTE_W-1:0] data_out_ff;
   sts_type           status_ff;
   logic [XFER_W-1:0] xfer_ff;
   logic              done_ff;

   logic [PTR_W-1:0]  wr_ptr_next, rd_ptr_next;
   logic              empty, full;
   logic              wr_en, rd_en, moved, done;
   sts_type           sts;
   logic [XFER_W-1:0] shown;

   // Ring occupancy: one slot is always left empty.
   assign wr_ptr_next = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_ptr_next = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
   assign empty       = (wr_ptr_ff == rd_ptr_ff);
   assign full        = (wr_ptr_next == rd_ptr_ff);

   // Decision for one item.
   always_comb begin
      sts        = STS_OK;
      done       = 1'b0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      moved      = 1'b0;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      writers_in = writers_ff;
      readers_in = readers_ff;
      case (act_type'(action))
         ACT_WRITE: begin
            if (readers_ff == '0) begin
               sts  = (bytes_ff != '0) ? STS_SHORT : STS_PIPE;
               done = 1'b1;
            end else if (full) begin
               sts = STS_BLOCK;
            end else begin
               wr_en     = 1'b1;
               wr_ptr_in = wr_ptr_next;
               moved     = 1'b1;
               done      = last;
            end
         end
         ACT_READ: begin
            if (empty) begin
               if (bytes_ff != '0) begin
                  sts  = STS_SHORT;
                  done = 1'b1;
               end else if (writers_ff == '0) begin
                  sts  = STS_EOF;
                  done = 1'b1;
               end else begin
                  sts = STS_BLOCK;
               end
            end else begin
               rd_en     = 1'b1;
               rd_ptr_in = rd_ptr_next;
               moved     = 1'b1;
               done      = last;
            end
         end
         ACT_ADD_WRITER: begin
            if (writers_ff != REF_LIMIT) begin
               writers_in = writers_ff + CNT_W'(1);
            end
         end
         ACT_CLOSE_WRITER: begin
            if (writers_ff != '0) begin
               writers_in = writers_ff - CNT_W'(1);
            end
            if (writers_in == '0 && readers_ff == '0) begin
               wr_ptr_in = '0;
               rd_ptr_in = '0;
            end
         end
         ACT_ADD_READER: begin
            if (readers_ff != REF_LIMIT) begin
               readers_in = readers_ff + CNT_W'(1);
            end
         end
         ACT_CLOSE_READER: begin
            if (readers_ff != '0) begin
               readers_in = readers_ff - CNT_W'(1);
            end
            if (readers_in == '0 && writers_ff == '0) begin
               wr_ptr_in = '0;
               rd_ptr_in = '0;
            end
         end
         default: begin
         end
      endcase
      shown    = (moved && bytes_ff != XFER_MAX) ? bytes_ff + XFER_W'(1) : bytes_ff;
      bytes_in = done ? '0 : shown;
   end

   // Control state: pointers, reference counts and the request count.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff  <= '0;
         wr_ptr_ff  <= '0;
         writers_ff <= '0;
         readers_ff <= '0;
         bytes_ff   <= '0;
      end else if (cmd.exec) begin
         rd_ptr_ff  <= rd_ptr_in;
         wr_ptr_ff  <= wr_ptr_in;
         writers_ff <= writers_in;
         readers_ff <= readers_in;
         bytes_ff   <= bytes_in;
      end
   end

   // Ring store write port.
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_ptr_ff] <= data_in;
      end
   end

   // Registered read port, which is also the data field of the result register.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         data_out_ff <= rd_en ? mem[rd_ptr_ff] : '0;
      end
   end

   // Remaining fields of the result register.
   always_ff @(posedge clock) begin
      if (cmd.exec && !cmd.hold) begin
         status_ff <= sts;
         xfer_ff   <= shown;
         done_ff   <= done;
      end
   end

   assign data_out     = data_out_ff;
   assign status       = status_ff;
   assign transferred  = xfer_ff;
   assign request_done = done_ff;

endmodule

// File: hw/rtl/refcounted_pipe_ring_buffer.sv
// Top level of the reference-counted pipe ring buffer.
// Depends on rcpipe_pkg, rcpipe_ctrl and rcpipe_dp.
//
// A byte pipe over a ring store of DEPTH bytes, of which DEPTH-1 can hold data,
// with reference counts (saturating at MAX_REFS) for the writer and reader ends.
// Each input item is one byte write, one byte read, or an open or close of one
// end, and gives exactly one result item, waiting in the cycle after it is accepted. A new
// item is accepted every cycle while results are taken; the pace is set by the
// single result register, which takes the next item only in a cycle where the
// waiting result leaves. The ring store has one write port and one registered
// read port, and each item uses at most one of them.
// A blocked access answers with would-block and changes nothing. When both
// counts are zero after a close the pointers return to zero; no reset sweep of
// the store is needed.
module refcounted_pipe_ring_buffer #(
   parameter int DEPTH    = 4096,
   parameter int MAX_REFS = 255
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [2:0] action, [10:3] data_in, [15:11] zero
   input  logic [rcpipe_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] data_out, [10:8] status, [26:11] transferred, [31:27] zero
   output logic [rcpipe_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                               rsp_tlast
);
   import rcpipe_pkg::*;

   localparam int PAD_W = RSP_TDATA_W - BYTE_W - STS_W - XFER_W;

   ctrl_cmd_type      cmd;
   logic [BYTE_W-1:0] data_out;
   sts_type           status;
   logic [XFER_W-1:0] transferred;
   logic              request_done;

   rcpipe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   rcpipe_dp #(
      .DEPTH    (DEPTH),
      .MAX_REFS (MAX_REFS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .action       (req_tdata[ACT_W-1:0]),
      .data_in      (req_tdata[ACT_W+BYTE_W-1:ACT_W]),
      .last         (req_tlast),
      .data_out     (data_out),
      .status       (status),
      .transferred  (transferred),
      .request_done (request_done)
   );

   // Pack the result item.
   assign rsp_tdata = {PAD_W'(0), transferred, status, data_out};
   assign rsp_tlast = request_done;

   // Every accepted item leaves a result waiting in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted item produced no result");

   // A would-block answer never ends a request.
   a_block_not_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status == STS_BLOCK) |-> !request_done)
      else $error("would-block result ended the request");

   // Broken pipe only on a request that has moved nothing yet.
   a_pipe_empty_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status == STS_PIPE) |-> (transferred == '0 && request_done))
      else $error("broken pipe on a request that already moved bytes");

   // A short end always closes a request that has moved bytes.
   a_short_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status == STS_SHORT) |-> (transferred != '0 && request_done))
      else $error("short end without moved bytes or without ending");

endmodule
